### design/tti_pkg.sv
package tti_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int DUR_W = 32;
	localparam int APB_AW = 5;

	typedef enum logic [2:0] {
		REG_DURATION = 3'd0,
		REG_START_DELAY = 3'd1,
		REG_LOOP_ENABLE = 3'd2,
		REG_YOYO_ENABLE = 3'd3,
		REG_EASE_MODE = 3'd4,
		REG_START_VALUE = 3'd5,
		REG_END_VALUE = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		EASE_LINEAR = 2'd0,
		EASE_IN_QUAD = 2'd1,
		EASE_OUT_QUAD = 2'd2,
		EASE_IN_OUT_QUAD = 2'd3
	} ease_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EASE,
		ST_BLEND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [15:0] tick_time;
		logic disabled;
	} tick_in_t;

	typedef struct packed {
		logic [16:0] eased_progress;
		logic signed [15:0] blended_value;
	} tick_out_t;

	// Start request for the restoring divider.
	typedef struct packed {
		logic start;
		logic [DUR_W-1:0] dividend;
		logic [DUR_W-1:0] divisor;
	} div_req_t;

endpackage

### design/tti_div.sv
// Restoring divider: one quotient bit per cycle.
// Low FRAC_BITS bits (the fraction) of {dividend, FRAC zeros} / divisor, plus
// the low bit of dividend / divisor (cycle parity); dividend < 2^32 so the DUR_W
// integer quotient bits are taken first, then FRAC fraction bits.
module tti_div #(
	parameter int FRAC_BITS = tti_pkg::FRAC_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input tti_pkg::div_req_t req,
	output logic done,
	output logic cyc_odd,
	output logic [FRAC_BITS-1:0] frac
);
	import tti_pkg::*;

	localparam int STEPS = DUR_W + FRAC_BITS;
	localparam int CW = $clog2(STEPS + 1);

	logic [DUR_W:0] rem_q;
	logic [DUR_W-1:0] shin_q;
	logic [DUR_W-1:0] dvs_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic odd_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	logic [DUR_W+1:0] trial;
	logic [DUR_W:0] shifted;
	logic quo_bit;

	always_comb begin
		shifted = {rem_q[DUR_W-1:0], shin_q[DUR_W-1]};
		trial = {1'b0, shifted} - {2'b00, dvs_q};
		quo_bit = ~trial[DUR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			shin_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= quo_bit ? trial[DUR_W:0] : shifted;
			shin_q <= {shin_q[DUR_W-2:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-2:0], quo_bit};
			// Last integer quotient bit is the cycle parity.
			if (cnt_q == CW'(FRAC_BITS + 1)) odd_q <= quo_bit;
		end
	end

	assign done = done_q;
	assign cyc_odd = odd_q;
	assign frac = quo_q;

endmodule

### design/tti_mul.sv
// Shift-add multiplier, one multiplier bit per cycle (unsigned a, signed b).
module tti_mul #(
	parameter int AW = 18,
	parameter int BW = 18
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [AW-1:0] a,
	input logic signed [BW-1:0] b,
	output logic done,
	output logic signed [AW+BW-1:0] prod
);
	localparam int CW = $clog2(AW + 1);
	localparam int PW = AW + BW;

	logic [AW-1:0] a_q;
	logic signed [PW-1:0] b_q;
	logic signed [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(AW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= PW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			if (a_q[0]) acc_q <= acc_q + b_q;
			a_q <= a_q >> 1;
			b_q <= b_q <<< 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### design/tween_track_interpolator.sv
// Tween track interpolator.
// Input channel (tick_*): one transaction per time tick, carrying a signed
// time delta and a disabled flag. The positive part of the delta is added to
// a saturating 32-bit elapsed-time counter on acceptance.
// Output channel (res_*): one transaction per enabled tick, carrying eased
// progress (Q1.FRAC) and the blended value. Disabled ticks give nothing.
// Configuration: APB-style port, registers at 4*index, always ready, readable.
// Flow: an accepted tick passes through the restoring divider, the shift-add
// multiplier for the easing square, the same multiplier again for the blend,
// and the result register. Ticks that need no division skip the divider;
// linear easing skips the square. A disabled tick leaves the sequencer idle.
// One tick at a time: tick_ready is high only while idle, so a new tick is
// taken only after the previous result has been accepted.
// Reset: clears elapsed time, the configuration registers and the sequencer;
// Stall: a finished result is held in the output register until res_ready;
// no new tick is taken meanwhile.
module tween_track_interpolator #(
	parameter int FRAC_BITS = tti_pkg::FRAC_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	output logic tick_ready,
	input tti_pkg::tick_in_t tick_data,
	output logic res_valid,
	input logic res_ready,
	output tti_pkg::tick_out_t res_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tti_pkg::APB_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tti_pkg::*;

	localparam int PW = FRAC_BITS + 1;
	localparam int MW = PW + 1;       // multiplier operand width
	localparam int SW = (MW > 17) ? MW : 17;  // signed operand width
	localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	// Configuration registers.
	logic [31:0] duration_q, start_delay_q;
	logic loop_q, yoyo_q;
	logic [1:0] ease_q;
	logic signed [15:0] start_q, end_q;
	logic [31:0] elapsed_q;

	logic wr_en;
	logic [2:0] widx;
	assign wr_en = psel & penable & pwrite;
	assign widx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= '0;
			start_delay_q <= '0;
			loop_q <= 1'b0;
			yoyo_q <= 1'b0;
			ease_q <= '0;
			start_q <= '0;
			end_q <= '0;
		end else if (wr_en) begin
			case (widx)
				REG_DURATION: duration_q <= pwdata;
				REG_START_DELAY: start_delay_q <= pwdata;
				REG_LOOP_ENABLE: loop_q <= pwdata[0];
				REG_YOYO_ENABLE: yoyo_q <= pwdata[0];
				REG_EASE_MODE: ease_q <= pwdata[1:0];
				REG_START_VALUE: start_q <= pwdata[15:0];
				REG_END_VALUE: end_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_DURATION: prdata = duration_q;
			REG_START_DELAY: prdata = start_delay_q;
			REG_LOOP_ENABLE: prdata = {31'd0, loop_q};
			REG_YOYO_ENABLE: prdata = {31'd0, yoyo_q};
			REG_EASE_MODE: prdata = {30'd0, ease_q};
			REG_START_VALUE: prdata = {{16{start_q[15]}}, start_q};
			REG_END_VALUE: prdata = {{16{end_q[15]}}, end_q};
			default: prdata = '0;
		endcase
	end

	// Sequencer.
	state_t state_q, state_d;
	logic tick_acc, res_acc;
	assign tick_ready = (state_q == ST_IDLE);
	assign tick_acc = tick_valid & tick_ready;
	assign res_acc = res_valid & res_ready;
	assign res_valid = (state_q == ST_OUT);

	// Elapsed-time accumulation; the new value is used by the same tick.
	logic [32:0] el_sum;
	logic [31:0] el_new;
	always_comb begin
		el_sum = {1'b0, elapsed_q} + 33'(tick_data.tick_time[14:0]);
		if (tick_data.tick_time[15] || tick_data.tick_time == '0) el_new = elapsed_q;
		else el_new = el_sum[32] ? '1 : el_sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) elapsed_q <= '0;
		else if (tick_acc) elapsed_q <= el_new;
	end

	// Raw progress classification at acceptance.
	logic [32:0] loc_full;
	logic [31:0] local_t;
	logic need_div, quick_one;
	always_comb begin
		loc_full = {1'b0, el_new} - {1'b0, start_delay_q};
		local_t = loc_full[31:0];
		quick_one = 1'b0;
		need_div = 1'b0;
		if (duration_q == '0) quick_one = 1'b1;
		else if (el_new <= start_delay_q) quick_one = 1'b0;
		else if (!loop_q && local_t >= duration_q) quick_one = 1'b1;
		else need_div = 1'b1;
	end

	div_req_t div_req;
	logic div_done, div_odd;
	logic [FRAC_BITS-1:0] div_frac;
	assign div_req.start = tick_acc & ~tick_data.disabled & need_div;
	assign div_req.dividend = local_t;
	assign div_req.divisor = duration_q;

	tti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req),
		.done(div_done), .cyc_odd(div_odd), .frac(div_frac)
	);

	// Shared multiplier: squares during easing, then the blend product.
	logic mul_start;
	logic [MW-1:0] mul_a;
	logic signed [SW-1:0] mul_b;
	logic mul_done;
	logic signed [MW+SW-1:0] mul_p;
	tti_mul #(.AW(MW), .BW(SW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	logic [PW-1:0] t_q;       // raw progress
	logic [PW-1:0] eased_q;
	logic ease_wait_q, blend_wait_q;
	logic [16:0] diff_w;

	// Easing operand and result shaping.
	logic [MW-1:0] sq_op;
	logic sq_pass;
	always_comb begin
		sq_pass = 1'b0;
		sq_op = '0;
		case (ease_t'(ease_q))
			EASE_IN_QUAD: sq_op = MW'(t_q);
			EASE_OUT_QUAD: sq_op = MW'(ONE - t_q);
			EASE_IN_OUT_QUAD: sq_op = (t_q < HALF) ? MW'(t_q) : (MW'(ONE) << 1) - (MW'(t_q) << 1);
			default: sq_pass = 1'b1;
		endcase
	end

	logic [2*MW-1:0] sq_val;
	logic [PW-1:0] ease_res;
	logic [2*MW:0] sq2;
	always_comb begin
		sq_val = (2*MW)'(mul_p[2*MW-1:0]);
		sq2 = {sq_val, 1'b0};
		ease_res = '0;
		case (ease_t'(ease_q))
			EASE_IN_QUAD: ease_res = PW'((sq_val + (2*MW)'(HALF)) >> FRAC_BITS);
			EASE_OUT_QUAD: ease_res = ONE - PW'((sq_val + (2*MW)'(HALF)) >> FRAC_BITS);
			EASE_IN_OUT_QUAD: begin
				if (t_q < HALF) ease_res = PW'((sq2 + (2*MW+1)'(HALF)) >> FRAC_BITS);
				else ease_res = ONE - PW'((sq_val + (2*MW)'(ONE)) >> (FRAC_BITS + 1));
			end
			default: ease_res = t_q;
		endcase
	end

	assign diff_w = 17'({end_q[15], end_q} - {start_q[15], start_q});

	always_comb begin
		mul_start = 1'b0;
		mul_a = sq_op;
		mul_b = SW'($signed({1'b0, sq_op[MW-2:0]}));
		if (state_q == ST_EASE && !ease_wait_q && !sq_pass) mul_start = 1'b1;
		if (state_q == ST_BLEND && !blend_wait_q) begin
			mul_start = 1'b1;
			mul_a = MW'(eased_q);
			mul_b = SW'($signed(diff_w));
		end
	end

	// Blend rounding: arithmetic shift floors.
	logic signed [MW+SW-1:0] num;
	logic signed [MW+SW-1:0] qv;
	logic signed [15:0] blend_res;
	always_comb begin
		num = mul_p + (MW+SW)'(HALF);
		qv = num >>> FRAC_BITS;
		blend_res = 16'(qv) + start_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (tick_acc && !tick_data.disabled)
				state_d = need_div ? ST_DIV : ST_EASE;
			ST_DIV: if (div_done) state_d = ST_EASE;
			ST_EASE: if (sq_pass || (ease_wait_q && mul_done)) state_d = ST_BLEND;
			ST_BLEND: if (blend_wait_q && mul_done) state_d = ST_OUT;
			ST_OUT: if (res_acc) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ease_wait_q <= 1'b0;
			blend_wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ease_wait_q <= (state_q == ST_EASE) && (state_d == ST_EASE);
			blend_wait_q <= (state_q == ST_BLEND) && (state_d == ST_BLEND);
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick_acc) t_q <= quick_one ? ONE : '0;
		if (state_q == ST_DIV && div_done) begin
			if (loop_q && yoyo_q && div_odd) t_q <= ONE - PW'(div_frac);
			else t_q <= PW'(div_frac);
		end
		if (state_q == ST_EASE && state_d == ST_BLEND) eased_q <= ease_res;
		if (state_q == ST_BLEND && state_d == ST_OUT) begin
			res_data.eased_progress <= 17'(eased_q);
			res_data.blended_value <= blend_res;
		end
	end

endmodule
